// ===== rtl/per_class_linked_list_manager_core_defines.svh =====
// ----------------------------------------------------------------------------
// per_class_linked_list_manager_core_defines
// assertion macros for the linked list manager rtl, used by pclm_ctrl
// ----------------------------------------------------------------------------
`ifndef PER_CLASS_LINKED_LIST_MANAGER_CORE_DEFINES_SVH
`define PER_CLASS_LINKED_LIST_MANAGER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pclm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_pkg
// shared constants and types of the per-class linked list manager
// ----------------------------------------------------------------------------
package pclm_pkg;

    localparam int CLASS_COUNT = 255;
    localparam int POOL_NODES  = 1024;

    localparam int SLOT_W = 10;
    localparam int CLS_W  = 8;
    localparam int CNT_W  = 11;
    localparam int PTR_W  = $clog2(POOL_NODES + 1);

    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_NODES);

    localparam logic FUNC_LINK   = 1'b0;
    localparam logic FUNC_UNLINK = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        ptr_t             head;
        ptr_t             tail;
        logic [CNT_W-1:0] count;
    } class_ent_t;

    typedef struct packed {
        logic cap;
        logic exe;
        logic prv;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic link_op;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pclm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_if
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface pclm_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [pclm_pkg::SLOT_W-1:0] node_slot;
    logic [pclm_pkg::CLS_W-1:0]  class_id;

    modport source (output valid, output func, output node_slot, output class_id,
                    input ready);
    modport sink   (input valid, input func, input node_slot, input class_id,
                    output ready);
endinterface

interface pclm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pclm_pkg::CNT_W-1:0]  class_count;
    logic [pclm_pkg::SLOT_W-1:0] head_slot;
    logic [pclm_pkg::SLOT_W-1:0] tail_slot;
    logic                        list_empty;

    modport source (output valid, output class_count, output head_slot,
                    output tail_slot, output list_empty, input ready);
    modport sink   (input valid, input class_count, input head_slot,
                    input tail_slot, input list_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/pclm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_dpath
// class table, node link memories, pointer update and response register
// ----------------------------------------------------------------------------
module pclm_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pclm_pkg::ctrl_cmd_t         cmd,
    output pclm_pkg::dp_sts_t           sts,
    input  logic                        req_func,
    input  logic [pclm_pkg::SLOT_W-1:0] req_node_slot,
    input  logic [pclm_pkg::CLS_W-1:0]  req_class_id,
    output logic [pclm_pkg::CNT_W-1:0]  rsp_class_count,
    output logic [pclm_pkg::SLOT_W-1:0] rsp_head_slot,
    output logic [pclm_pkg::SLOT_W-1:0] rsp_tail_slot,
    output logic                        rsp_list_empty
);
    import pclm_pkg::*;

    class_ent_t             class_mem [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] class_vld_reg;
    ptr_t                   next_mem [POOL_NODES];
    ptr_t                   prev_mem [POOL_NODES];

    logic              func_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CLS_W-1:0]  cls_reg;
    class_ent_t        class_rd_reg;
    logic              class_rd_vld_reg;
    ptr_t              next_rd_reg;
    ptr_t              prev_rd_reg;
    logic              prv_en_reg;
    logic [SLOT_W-1:0] prv_addr_reg;

    logic [CNT_W-1:0]  out_count_reg;
    logic [SLOT_W-1:0] out_head_reg;
    logic [SLOT_W-1:0] out_tail_reg;
    logic              out_empty_reg;

    logic              req_cls_ok;
    logic              cls_ok;
    logic              op_ok;
    ptr_t              slot_ptr;
    class_ent_t        cur_ent;
    class_ent_t        new_ent;
    class_ent_t        res_ent;

    logic              nx_we;
    logic [SLOT_W-1:0] nx_waddr;
    ptr_t              nx_wdata;
    logic              pv_we;
    logic [SLOT_W-1:0] pv_waddr;
    ptr_t              pv_wdata;

    assign req_cls_ok = (32'(req_class_id) < CLASS_COUNT);
    assign cls_ok     = (32'(cls_reg) < CLASS_COUNT);
    assign op_ok      = cls_ok && (32'(slot_reg) < POOL_NODES);
    assign slot_ptr   = PTR_W'(slot_reg);
    assign sts.link_op = (func_reg == FUNC_LINK);

    // request capture and memory reads
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            func_reg         <= req_func;
            slot_reg         <= req_node_slot;
            cls_reg          <= req_class_id;
            class_rd_vld_reg <= req_cls_ok ? class_vld_reg[req_class_id] : 1'b0;
            if (req_cls_ok)
            begin
                class_rd_reg <= class_mem[req_class_id];
            end
            next_rd_reg <= next_mem[req_node_slot];
            prev_rd_reg <= prev_mem[req_node_slot];
        end
    end

    always_comb
    begin
        if (class_rd_vld_reg)
        begin
            cur_ent = class_rd_reg;
        end
        else
        begin
            cur_ent.head  = NIL_PTR;
            cur_ent.tail  = NIL_PTR;
            cur_ent.count = '0;
        end
    end

    // class entry after the operation
    always_comb
    begin
        new_ent = cur_ent;
        if (func_reg == FUNC_LINK)
        begin
            new_ent.head = slot_ptr;
            if (cur_ent.tail == NIL_PTR)
            begin
                new_ent.tail = slot_ptr;
            end
            if (cur_ent.count < CNT_W'(POOL_NODES))
            begin
                new_ent.count = cur_ent.count + CNT_W'(1);
            end
        end
        else
        begin
            if (cur_ent.head == slot_ptr)
            begin
                new_ent.head = next_rd_reg;
            end
            if (cur_ent.tail == slot_ptr)
            begin
                new_ent.tail = prev_rd_reg;
            end
            if (cur_ent.count != '0)
            begin
                new_ent.count = cur_ent.count - CNT_W'(1);
            end
        end
        res_ent = op_ok ? new_ent : cur_ent;
    end

    // node memory write ports
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = slot_reg;
        nx_wdata = cur_ent.head;
        pv_we    = 1'b0;
        pv_waddr = slot_reg;
        pv_wdata = NIL_PTR;
        if (cmd.exe && op_ok)
        begin
            if (func_reg == FUNC_LINK)
            begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            else
            begin
                nx_we    = (prev_rd_reg != NIL_PTR);
                nx_waddr = prev_rd_reg[SLOT_W-1:0];
                nx_wdata = next_rd_reg;
                pv_we    = (next_rd_reg != NIL_PTR);
                pv_waddr = next_rd_reg[SLOT_W-1:0];
                pv_wdata = prev_rd_reg;
            end
        end
        else if (cmd.prv)
        begin
            pv_we    = prv_en_reg;
            pv_waddr = prv_addr_reg;
            pv_wdata = slot_ptr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (cmd.exe && op_ok)
        begin
            class_mem[cls_reg] <= new_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_vld_reg <= '0;
        end
        else if (cmd.exe && op_ok)
        begin
            class_vld_reg[cls_reg] <= 1'b1;
        end
    end

    // old head gets its back pointer in the following cycle
    always_ff @(posedge clk)
    begin
        if (cmd.exe)
        begin
            prv_en_reg   <= op_ok && (func_reg == FUNC_LINK) && (cur_ent.head != NIL_PTR);
            prv_addr_reg <= cur_ent.head[SLOT_W-1:0];
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cls_ok)
            begin
                out_count_reg <= res_ent.count;
                out_head_reg  <= (res_ent.head == NIL_PTR) ? '0 : res_ent.head[SLOT_W-1:0];
                out_tail_reg  <= (res_ent.tail == NIL_PTR) ? '0 : res_ent.tail[SLOT_W-1:0];
                out_empty_reg <= (res_ent.head == NIL_PTR);
            end
            else
            begin
                out_count_reg <= '0;
                out_head_reg  <= '0;
                out_tail_reg  <= '0;
                out_empty_reg <= 1'b1;
            end
        end
    end

    assign rsp_class_count = out_count_reg;
    assign rsp_head_slot   = out_head_reg;
    assign rsp_tail_slot   = out_tail_reg;
    assign rsp_list_empty  = out_empty_reg;

endmodule

`default_nettype wire

// ===== rtl/pclm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_ctrl
// operation sequencer and response valid tracking
// ----------------------------------------------------------------------------
`include "per_class_linked_list_manager_core_defines.svh"

module pclm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  pclm_pkg::dp_sts_t   sts,
    output pclm_pkg::ctrl_cmd_t cmd
);
    import pclm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_PREV = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exe    = 1'b1;
                state_next = sts.link_op ? ST_PREV : ST_DONE;
            end
            ST_PREV:
            begin
                cmd.prv    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

    `PCLM_ASSERT_NEXT(a_accept_to_exec, req_valid && req_ready, state_reg == ST_EXEC, "accepted word did not start execution")
    `PCLM_ASSERT_NOW(a_load_free, cmd.load, !out_valid_reg || rsp_ready, "response overwritten before taken")
    `PCLM_ASSERT_NOW(a_prev_link_only, state_reg == ST_PREV, sts.link_op, "back pointer pass on unlink")
    `PCLM_ASSERT_NOW(a_valid_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE), "response valid without completion")

endmodule

`default_nettype wire

// ===== rtl/per_class_linked_list_manager_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_class_linked_list_manager_core
// one doubly linked list per class over a shared pool of node slots
// ----------------------------------------------------------------------------
// usage
//   req carries one word per operation: func (link at head / unlink),
//   node_slot and class_id. rsp returns one word per request with the
//   class count, head slot, tail slot and an empty flag after the operation.
//   an out-of-range class gives count 0, head 0, tail 0 and empty set.
// timing
//   a request is taken in the idle state; an unlink then runs exec and done,
//   a link exec, prev and done, as the back pointer memory has a single write
//   port and a link writes it twice. the response is loaded into the output
//   register in the done state.
// reset
//   all class lists read empty right after reset, through per-class valid
//   bits; no clearing pass is needed and requests are taken at once.
// back-pressure
//   the response register holds its word until taken; a following request
//   is accepted and executed meanwhile and waits only to load its response.
// ----------------------------------------------------------------------------
module per_class_linked_list_manager_core (
    input  logic       clk,
    input  logic       rst_n,
    pclm_req_if.sink   req,
    pclm_rsp_if.source rsp
);
    import pclm_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;
    logic      req_ready_w;
    logic      rsp_valid_w;

    pclm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready_w),
        .rsp_valid (rsp_valid_w),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pclm_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_func        (req.func),
        .req_node_slot   (req.node_slot),
        .req_class_id    (req.class_id),
        .rsp_class_count (rsp.class_count),
        .rsp_head_slot   (rsp.head_slot),
        .rsp_tail_slot   (rsp.tail_slot),
        .rsp_list_empty  (rsp.list_empty)
    );

    assign req.ready = req_ready_w;
    assign rsp.valid = rsp_valid_w;

endmodule

`default_nettype wire
